>>> hw/rtl/ufhb_pkg.sv
`default_nettype none
package ufhb_pkg;

  localparam int MaxFrameBytes = 4096;
  localparam int HdrBytes      = 42;
  localparam int UdpBytes      = 8;
  localparam int IpUdpBytes    = 28;
  localparam int IdxW          = $clog2(HdrBytes);
  localparam int SumW          = 19;

  localparam logic [15:0] WordVerIhl   = 16'h4500;
  localparam logic [15:0] WordTtlProto = 16'h6411;
  localparam logic [7:0]  ByteVerIhl   = 8'h45;
  localparam logic [7:0]  ByteTtl      = 8'd100;
  localparam logic [7:0]  ByteProtoUdp = 8'd17;
  localparam logic [7:0]  ByteEtypeHi  = 8'h08;

  typedef enum logic [1:0] {
    RegLocalMac = 2'd0,
    RegPeerMac  = 2'd1,
    RegLocalIp  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [47:0] src_mac;
    logic [47:0] peer_mac;
    logic [31:0] src_ip;
  } cfg_t;

  typedef struct packed {
    logic [15:0]     sport;
    logic [31:0]     dst_ip;
    logic [15:0]     dport;
    logic [11:0]     len;
    logic [SumW-1:0] sum;
    logic            too_long;
  } req_t;

endpackage
`default_nettype wire

>>> hw/rtl/ufhb_front.sv
`default_nettype none
module ufhb_front
  import ufhb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] source_port_i,
  input  wire logic [31:0] destination_ip_i,
  input  wire logic [15:0] destination_port_i,
  input  wire logic [11:0] payload_length_i,
  output logic             push_valid_o,
  input  wire logic        push_ready_i,
  output req_t             push_data_o
);

  logic        valid_q, valid_d;
  req_t        req_q;
  req_t        req_d;
  logic        take;
  logic [15:0] tot_len;

  assign in_ready_o = !valid_q || push_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign tot_len    = 16'(payload_length_i) + 16'(IpUdpBytes);

  always_comb begin
    req_d          = req_q;
    req_d.sport    = source_port_i;
    req_d.dst_ip   = destination_ip_i;
    req_d.dport    = destination_port_i;
    req_d.len      = payload_length_i;
    req_d.too_long = (32'(payload_length_i) + 32'(HdrBytes)) > 32'(MaxFrameBytes);
    req_d.sum      = SumW'(WordVerIhl) + SumW'(tot_len) + SumW'(WordTtlProto)
                   + SumW'(cfg_i.src_ip[31:16]) + SumW'(cfg_i.src_ip[15:0])
                   + SumW'(destination_ip_i[31:16]) + SumW'(destination_ip_i[15:0]);
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= req_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_data_o  = req_q;

endmodule
`default_nettype wire

>>> hw/rtl/ufhb_queue.sv
`default_nettype none
module ufhb_queue
  import ufhb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire req_t push_data_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output req_t      pop_data_o
);

  req_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = count_q != 2'd2;
  assign pop_valid_o  = count_q != 2'd0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ufhb_back.sv
`default_nettype none
module ufhb_back
  import ufhb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       pop_valid_i,
  output logic            pop_ready_o,
  input  wire req_t       pop_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      frame_byte_o,
  output logic            last_byte_o,
  output logic            too_long_o
);

  logic            busy_q, busy_d;
  logic [IdxW-1:0] idx_q, idx_d;
  req_t            cur_q;
  logic [15:0]     csum_q, csum_d;
  logic            ov_q, ov_d;
  logic [7:0]      byte_q, byte_d;
  logic            last_q, last_d;
  logic            err_q, err_d;
  logic            emit, finish, load;
  logic [16:0]     fold1;
  logic [16:0]     fold2;
  logic [15:0]     tot_len, udp_len;

  assign emit        = busy_q && (!ov_q || out_ready_i);
  assign finish      = emit && (cur_q.too_long || idx_q == IdxW'(HdrBytes - 1));
  assign pop_ready_o = !busy_q || finish;
  assign load        = pop_valid_i && pop_ready_o;

  assign fold1   = 17'(pop_data_i.sum[15:0]) + 17'(pop_data_i.sum[SumW-1:16]);
  assign fold2   = 17'(fold1[15:0]) + 17'(fold1[16]);
  assign csum_d  = ~fold2[15:0];
  assign tot_len = 16'(cur_q.len) + 16'(IpUdpBytes);
  assign udp_len = 16'(cur_q.len) + 16'(UdpBytes);

  always_comb begin
    case (idx_q)
      6'd0:    byte_d = cfg_i.peer_mac[47:40];
      6'd1:    byte_d = cfg_i.peer_mac[39:32];
      6'd2:    byte_d = cfg_i.peer_mac[31:24];
      6'd3:    byte_d = cfg_i.peer_mac[23:16];
      6'd4:    byte_d = cfg_i.peer_mac[15:8];
      6'd5:    byte_d = cfg_i.peer_mac[7:0];
      6'd6:    byte_d = cfg_i.src_mac[47:40];
      6'd7:    byte_d = cfg_i.src_mac[39:32];
      6'd8:    byte_d = cfg_i.src_mac[31:24];
      6'd9:    byte_d = cfg_i.src_mac[23:16];
      6'd10:   byte_d = cfg_i.src_mac[15:8];
      6'd11:   byte_d = cfg_i.src_mac[7:0];
      6'd12:   byte_d = ByteEtypeHi;
      6'd14:   byte_d = ByteVerIhl;
      6'd16:   byte_d = tot_len[15:8];
      6'd17:   byte_d = tot_len[7:0];
      6'd22:   byte_d = ByteTtl;
      6'd23:   byte_d = ByteProtoUdp;
      6'd24:   byte_d = csum_q[15:8];
      6'd25:   byte_d = csum_q[7:0];
      6'd26:   byte_d = cfg_i.src_ip[31:24];
      6'd27:   byte_d = cfg_i.src_ip[23:16];
      6'd28:   byte_d = cfg_i.src_ip[15:8];
      6'd29:   byte_d = cfg_i.src_ip[7:0];
      6'd30:   byte_d = cur_q.dst_ip[31:24];
      6'd31:   byte_d = cur_q.dst_ip[23:16];
      6'd32:   byte_d = cur_q.dst_ip[15:8];
      6'd33:   byte_d = cur_q.dst_ip[7:0];
      6'd34:   byte_d = cur_q.sport[15:8];
      6'd35:   byte_d = cur_q.sport[7:0];
      6'd36:   byte_d = cur_q.dport[15:8];
      6'd37:   byte_d = cur_q.dport[7:0];
      6'd38:   byte_d = udp_len[15:8];
      6'd39:   byte_d = udp_len[7:0];
      default: byte_d = 8'd0;
    endcase
    if (cur_q.too_long) begin
      byte_d = 8'd0;
    end
  end

  assign last_d = finish;
  assign err_d  = cur_q.too_long;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (emit) begin
      idx_d = idx_q + IdxW'(1);
    end
    if (finish) begin
      busy_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_comb begin
    ov_d = ov_q;
    if (emit) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q  <= pop_data_i;
      csum_q <= csum_d;
    end
    if (emit) begin
      byte_q <= byte_d;
      last_q <= last_d;
      err_q  <= err_d;
    end
  end

  assign out_valid_o  = ov_q;
  assign frame_byte_o = byte_q;
  assign last_byte_o  = last_q;
  assign too_long_o   = err_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < IdxW'(HdrBytes)))
    else $error("byte index past header end");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && cur_q.too_long) |=> (out_valid_o && last_byte_o && frame_byte_o == 8'd0))
    else $error("error item not a single zero last byte");

  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (busy_q && idx_q == '0))
    else $error("loaded item does not start at first byte");

  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !cur_q.too_long && idx_q == IdxW'(HdrBytes - 1)) |=> last_byte_o)
    else $error("final header byte not marked last");

endmodule
`default_nettype wire

>>> hw/rtl/udp_frame_header_builder.sv
// Builds the 42-byte Ethernet/IPv4/UDP header for each send request and
// streams it one byte per cycle in wire order unless out_ready_i stalls the
// output, last_byte_o marking byte 42. A request whose payload plus header
// exceeds the maximum frame size yields a single zero byte with too_long_o
// and last_byte_o set. A byte-wide output serializer streams each header;
// the front stage computes the IPv4 checksum sum and a two-entry queue lets
// new requests be taken while the previous header is still streaming. Write
// the address registers only while the block is idle.
`default_nettype none
module udp_frame_header_builder
  import ufhb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [47:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] source_port_i,
  input  wire logic [31:0] destination_ip_i,
  input  wire logic [15:0] destination_port_i,
  input  wire logic [11:0] payload_length_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       frame_byte_o,
  output logic             last_byte_o,
  output logic             too_long_o
);

  cfg_t cfg_q;
  logic push_valid, push_ready, pop_valid, pop_ready;
  req_t push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_mac  <= 48'h525400123456;
      cfg_q.peer_mac <= 48'h52550A000202;
      cfg_q.src_ip   <= 32'h0A00020F;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegLocalMac: cfg_q.src_mac  <= cfg_data_i;
        RegPeerMac:  cfg_q.peer_mac <= cfg_data_i;
        RegLocalIp:  cfg_q.src_ip   <= cfg_data_i[31:0];
        default:     cfg_q          <= cfg_q;
      endcase
    end
  end

  ufhb_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .source_port_i      (source_port_i),
    .destination_ip_i   (destination_ip_i),
    .destination_port_i (destination_port_i),
    .payload_length_i   (payload_length_i),
    .push_valid_o       (push_valid),
    .push_ready_i       (push_ready),
    .push_data_o        (push_data)
  );

  ufhb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  ufhb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o),
    .too_long_o   (too_long_o)
  );

endmodule
`default_nettype wire
